// ===== sv/cpp_pkg.sv =====
// ============================================================================
// cpp_pkg
// Shared types, constants and helpers for the camera point projection block.
// ============================================================================
package cpp_pkg;

    localparam int VAL_W  = 63;
    localparam int MAG_W  = 62;
    localparam int LO_W   = 32;
    localparam int HI_W   = MAG_W - LO_W;
    localparam int PROD_W = 2 * MAG_W;
    localparam int DIV_Q_W = 64;
    localparam int DIV_STEPS_DEFAULT = 2;
    localparam int MUL_LAT = 4;
    localparam int ADDR_W  = 5;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [MAG_W-1:0] mag_t;

    typedef struct packed {
        logic vld;
        logic zero;
    } ctrl_t;

    localparam mag_t SAT_MAG = mag_t'(1) << 61;
    localparam logic signed [VAL_W:0] SAT_WIDE = $signed({2'b00, SAT_MAG});
    localparam val_t ONE_Q32 = val_t'(1) <<< 32;

    localparam logic [2:0] REG_K1 = 3'd0;
    localparam logic [2:0] REG_K2 = 3'd1;
    localparam logic [2:0] REG_FX = 3'd2;
    localparam logic [2:0] REG_FY = 3'd3;
    localparam logic [2:0] REG_CX = 3'd4;
    localparam logic [2:0] REG_CY = 3'd5;

    function automatic val_t sat_add(input val_t a, input val_t b);
        logic signed [VAL_W:0] s;
        s = (VAL_W + 1)'(a) + (VAL_W + 1)'(b);
        if (s > SAT_WIDE) begin
            return val_t'(SAT_WIDE);
        end else if (s < -SAT_WIDE) begin
            return val_t'(-SAT_WIDE);
        end
        return val_t'(s);
    endfunction

endpackage

// ===== sv/cpp_delay.sv =====
// ============================================================================
// cpp_delay
// Fixed-length register line that aligns data with the arithmetic pipeline.
// ============================================================================
module cpp_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] line_reg [0:DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                line_reg[i] <= '0;
            end
        end
        else
        begin
            line_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign dout = line_reg[DEPTH-1];

endmodule

// ===== sv/cpp_mul.sv =====
// ============================================================================
// cpp_mul
// Four-stage signed multiply with truncating right shift and saturation.
// ============================================================================
module cpp_mul #(
    parameter int SHIFT = 32
) (
    input  logic          clk,
    input  cpp_pkg::val_t a,
    input  cpp_pkg::val_t b,
    output cpp_pkg::val_t p
);

    localparam int MAG_W  = cpp_pkg::MAG_W;
    localparam int LO_W   = cpp_pkg::LO_W;
    localparam int HI_W   = cpp_pkg::HI_W;
    localparam int PROD_W = cpp_pkg::PROD_W;

    logic                  neg1_reg, neg2_reg, neg3_reg;
    cpp_pkg::mag_t         ma_reg, mb_reg;
    logic [2*LO_W-1:0]     pp00_reg;
    logic [LO_W+HI_W-1:0]  pp01_reg, pp10_reg;
    logic [2*HI_W-1:0]     pp11_reg;
    logic [PROD_W-1:0]     prod_reg;
    cpp_pkg::val_t         p_reg;

    logic [PROD_W-1:0]     shifted;
    logic                  over;
    cpp_pkg::mag_t         mres;
    cpp_pkg::val_t         p_next;

    always_ff @(posedge clk)
    begin
        neg1_reg <= a[cpp_pkg::VAL_W-1] ^ b[cpp_pkg::VAL_W-1];
        ma_reg   <= cpp_pkg::mag_t'(a[cpp_pkg::VAL_W-1] ? -a : a);
        mb_reg   <= cpp_pkg::mag_t'(b[cpp_pkg::VAL_W-1] ? -b : b);

        neg2_reg <= neg1_reg;
        pp00_reg <= ma_reg[LO_W-1:0] * mb_reg[LO_W-1:0];
        pp01_reg <= ma_reg[LO_W-1:0] * mb_reg[MAG_W-1:LO_W];
        pp10_reg <= ma_reg[MAG_W-1:LO_W] * mb_reg[LO_W-1:0];
        pp11_reg <= ma_reg[MAG_W-1:LO_W] * mb_reg[MAG_W-1:LO_W];

        neg3_reg <= neg2_reg;
        prod_reg <= PROD_W'(pp00_reg)
                  + (PROD_W'(pp01_reg) << LO_W)
                  + (PROD_W'(pp10_reg) << LO_W)
                  + (PROD_W'(pp11_reg) << (2 * LO_W));

        p_reg <= p_next;
    end

    always_comb
    begin
        shifted = prod_reg >> SHIFT;
        over    = (|shifted[PROD_W-1:MAG_W]) || (shifted[MAG_W-1:0] > cpp_pkg::SAT_MAG);
        mres    = over ? cpp_pkg::SAT_MAG : shifted[MAG_W-1:0];
        if (neg3_reg && (mres != '0))
        begin
            p_next = -$signed({1'b0, mres});
        end
        else
        begin
            p_next = $signed({1'b0, mres});
        end
    end

    assign p = p_reg;

endmodule

// ===== sv/cpp_div.sv =====
// ============================================================================
// cpp_div
// Pipelined restoring divider giving (n * 2^32) / d, truncated and saturated.
// ============================================================================
module cpp_div #(
    parameter int STEPS = cpp_pkg::DIV_STEPS_DEFAULT
) (
    input  logic               clk,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output cpp_pkg::val_t      quo
);

    localparam int QW  = cpp_pkg::DIV_Q_W;
    localparam int NST = QW / STEPS;

    logic [31:0]   rem_reg [0:NST];
    logic [QW-1:0] qd_reg  [0:NST];
    logic [31:0]   dv_reg  [0:NST];
    logic          neg_reg [0:NST];
    cpp_pkg::val_t quo_reg;

    logic [QW-1:0] qfin;
    logic          over;
    cpp_pkg::mag_t mres;
    cpp_pkg::val_t quo_next;

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= '0;
        qd_reg[0]  <= {(num[31] ? 32'(-num) : 32'(num)), 32'd0};
        dv_reg[0]  <= den[31] ? 32'(-den) : 32'(den);
        neg_reg[0] <= num[31] ^ den[31];
    end

    for (genvar k = 0; k < NST; k++)
    begin : g_stage
        logic [31:0]   rem_c [0:STEPS];
        logic [QW-1:0] qd_c  [0:STEPS];
        logic [32:0]   trial [0:STEPS-1];

        always_comb
        begin
            rem_c[0] = rem_reg[k];
            qd_c[0]  = qd_reg[k];
            for (int s = 0; s < STEPS; s++)
            begin
                trial[s] = {rem_c[s], qd_c[s][QW-1]};
                if (trial[s] >= {1'b0, dv_reg[k]})
                begin
                    rem_c[s+1] = 32'(trial[s] - {1'b0, dv_reg[k]});
                    qd_c[s+1]  = {qd_c[s][QW-2:0], 1'b1};
                end
                else
                begin
                    rem_c[s+1] = trial[s][31:0];
                    qd_c[s+1]  = {qd_c[s][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= rem_c[STEPS];
            qd_reg[k+1]  <= qd_c[STEPS];
            dv_reg[k+1]  <= dv_reg[k];
            neg_reg[k+1] <= neg_reg[k];
        end
    end

    always_comb
    begin
        qfin = qd_reg[NST];
        over = qfin > QW'(cpp_pkg::SAT_MAG);
        mres = over ? cpp_pkg::SAT_MAG : qfin[cpp_pkg::MAG_W-1:0];
        if (neg_reg[NST] && (mres != '0))
        begin
            quo_next = -$signed({1'b0, mres});
        end
        else
        begin
            quo_next = $signed({1'b0, mres});
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
    end

    assign quo = quo_reg;

endmodule

// ===== sv/camera_point_projection.sv =====
// ============================================================================
// camera_point_projection
// Pinhole projection of camera-frame points with k1/k2 radial distortion.
// ============================================================================
// A point beat (point_x, point_y, point_z, signed Q16.16) is taken at each
// rising edge where start is high; busy is always low, so one point may be
// issued in every cycle. Each point yields exactly one result beat
// (pixel_x, pixel_y, invalid, clipped), shown for one cycle with done high.
// With the default of two quotient bits per divider stage, the divider
// stages make up most of the pipeline; the rest comes mainly from the chain
// of four-stage multipliers. Throughput is one point per cycle. Results
// cannot be held off by the receiver and are never buffered. Calibration
// registers sit on the APB port (k1, k2, focal x, focal y, centre x, centre
// y at byte addresses 0 to 20); the user must write them only while no
// point is in flight, and the block itself does not enforce this. Reset
// restores unit focal lengths, zero coefficients and centres, and clears
// all beats in flight.
// ============================================================================
module camera_point_projection #(
    parameter int DIV_STEPS = cpp_pkg::DIV_STEPS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [31:0]         point_x,
    input  logic signed [31:0]         point_y,
    input  logic signed [31:0]         point_z,
    output logic                       done,
    output logic signed [15:0]         pixel_x,
    output logic signed [15:0]         pixel_y,
    output logic                       invalid,
    output logic                       clipped,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cpp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int MUL_LAT = cpp_pkg::MUL_LAT;
    localparam int DIV_LAT = cpp_pkg::DIV_Q_W / DIV_STEPS + 2;
    localparam int T_UV  = DIV_LAT;
    localparam int T_R2  = T_UV + MUL_LAT + 1;
    localparam int T_K   = T_R2 + MUL_LAT;
    localparam int T_F   = T_K + MUL_LAT + 1;
    localparam int T_UF  = T_F + MUL_LAT;
    localparam int T_FOC = T_UF + MUL_LAT;
    localparam int T_S   = T_FOC + 1;

    logic [31:0] k1_reg, k2_reg, fx_reg, fy_reg, cx_reg, cy_reg;
    logic [2:0]  reg_idx;
    logic        wr_en;

    logic               in_vld_reg;
    logic signed [31:0] in_x_reg, in_y_reg, in_z_reg;
    cpp_pkg::ctrl_t     ctrl_in, ctrl_s;

    cpp_pkg::val_t u_q, v_q, u_d, v_d, uu, vv, r2_reg, r4, k1r2, k2r4;
    cpp_pkg::val_t f1_reg, f1_d, f_reg, uf, vf, ufx, vfy, sx_reg, sy_reg;
    cpp_pkg::val_t k1_v, k2_v, fx_v, fy_v, cx_q, cy_q;

    logic [16:0]        pix_x_c, pix_y_c;
    logic               done_reg, invalid_reg, clipped_reg;
    logic signed [15:0] pixel_x_reg, pixel_y_reg;

    function automatic logic [16:0] to_pixel(input cpp_pkg::val_t s);
        cpp_pkg::val_t m;
        logic [29:0]   w;
        m = s[cpp_pkg::VAL_W-1] ? -s : s;
        w = m[61:32];
        if (!s[cpp_pkg::VAL_W-1])
        begin
            if (w > 30'd32767)
            begin
                return {1'b1, 16'h7fff};
            end
            return {1'b0, w[15:0]};
        end
        if (w > 30'd32768)
        begin
            return {1'b1, 16'h8000};
        end
        return {1'b0, 16'(-w[15:0])};
    endfunction

    // Configuration port.
    assign reg_idx = paddr[cpp_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k1_reg <= '0;
            k2_reg <= '0;
            fx_reg <= 32'h0001_0000;
            fy_reg <= 32'h0001_0000;
            cx_reg <= '0;
            cy_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                cpp_pkg::REG_K1: k1_reg <= pwdata;
                cpp_pkg::REG_K2: k2_reg <= pwdata;
                cpp_pkg::REG_FX: fx_reg <= pwdata;
                cpp_pkg::REG_FY: fy_reg <= pwdata;
                cpp_pkg::REG_CX: cx_reg <= pwdata;
                cpp_pkg::REG_CY: cy_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            cpp_pkg::REG_K1: prdata = k1_reg;
            cpp_pkg::REG_K2: prdata = k2_reg;
            cpp_pkg::REG_FX: prdata = fx_reg;
            cpp_pkg::REG_FY: prdata = fy_reg;
            cpp_pkg::REG_CX: prdata = cx_reg;
            cpp_pkg::REG_CY: prdata = cy_reg;
            default:         prdata = '0;
        endcase
    end

    assign k1_v = cpp_pkg::val_t'($signed(k1_reg));
    assign k2_v = cpp_pkg::val_t'($signed(k2_reg));
    assign fx_v = cpp_pkg::val_t'(fx_reg);
    assign fy_v = cpp_pkg::val_t'(fy_reg);
    assign cx_q = cpp_pkg::val_t'($signed(cx_reg)) <<< 16;
    assign cy_q = cpp_pkg::val_t'($signed(cy_reg)) <<< 16;

    // Input beat register.
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        in_x_reg <= point_x;
        in_y_reg <= point_y;
        in_z_reg <= point_z;
    end

    assign ctrl_in.vld  = in_vld_reg;
    assign ctrl_in.zero = (in_z_reg == '0);

    cpp_delay #(.WIDTH($bits(cpp_pkg::ctrl_t)), .DEPTH(T_S)) u_ctrl_dly (
        .clk(clk), .rst_n(rst_n), .din(ctrl_in), .dout(ctrl_s)
    );

    // Normalised coordinates.
    cpp_div #(.STEPS(DIV_STEPS)) u_div_x (
        .clk(clk), .num(in_x_reg), .den(in_z_reg), .quo(u_q)
    );
    cpp_div #(.STEPS(DIV_STEPS)) u_div_y (
        .clk(clk), .num(in_y_reg), .den(in_z_reg), .quo(v_q)
    );

    // Radius terms and distortion factor.
    cpp_mul #(.SHIFT(32)) u_mul_uu (.clk(clk), .a(u_q), .b(u_q), .p(uu));
    cpp_mul #(.SHIFT(32)) u_mul_vv (.clk(clk), .a(v_q), .b(v_q), .p(vv));
    cpp_mul #(.SHIFT(32)) u_mul_r4 (.clk(clk), .a(r2_reg), .b(r2_reg), .p(r4));
    cpp_mul #(.SHIFT(24)) u_mul_k1 (.clk(clk), .a(k1_v), .b(r2_reg), .p(k1r2));
    cpp_mul #(.SHIFT(24)) u_mul_k2 (.clk(clk), .a(k2_v), .b(r4), .p(k2r4));

    cpp_delay #(.WIDTH(cpp_pkg::VAL_W), .DEPTH(MUL_LAT - 1)) u_f1_dly (
        .clk(clk), .rst_n(rst_n), .din(f1_reg), .dout(f1_d)
    );

    always_ff @(posedge clk)
    begin
        r2_reg <= cpp_pkg::sat_add(uu, vv);
        f1_reg <= cpp_pkg::sat_add(cpp_pkg::ONE_Q32, k1r2);
        f_reg  <= cpp_pkg::sat_add(f1_d, k2r4);
    end

    // Distorted coordinates, focal scaling and principal point.
    cpp_delay #(.WIDTH(cpp_pkg::VAL_W), .DEPTH(T_F - T_UV)) u_u_dly (
        .clk(clk), .rst_n(rst_n), .din(u_q), .dout(u_d)
    );
    cpp_delay #(.WIDTH(cpp_pkg::VAL_W), .DEPTH(T_F - T_UV)) u_v_dly (
        .clk(clk), .rst_n(rst_n), .din(v_q), .dout(v_d)
    );

    cpp_mul #(.SHIFT(32)) u_mul_uf (.clk(clk), .a(u_d), .b(f_reg), .p(uf));
    cpp_mul #(.SHIFT(32)) u_mul_vf (.clk(clk), .a(v_d), .b(f_reg), .p(vf));
    cpp_mul #(.SHIFT(16)) u_mul_fx (.clk(clk), .a(uf), .b(fx_v), .p(ufx));
    cpp_mul #(.SHIFT(16)) u_mul_fy (.clk(clk), .a(vf), .b(fy_v), .p(vfy));

    always_ff @(posedge clk)
    begin
        sx_reg <= cpp_pkg::sat_add(ufx, cx_q);
        sy_reg <= cpp_pkg::sat_add(vfy, cy_q);
    end

    // Result beat.
    assign pix_x_c = to_pixel(sx_reg);
    assign pix_y_c = to_pixel(sy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl_s.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_s.zero)
        begin
            pixel_x_reg <= '0;
            pixel_y_reg <= '0;
            invalid_reg <= 1'b1;
            clipped_reg <= 1'b0;
        end
        else
        begin
            pixel_x_reg <= $signed(pix_x_c[15:0]);
            pixel_y_reg <= $signed(pix_y_c[15:0]);
            invalid_reg <= 1'b0;
            clipped_reg <= pix_x_c[16] | pix_y_c[16];
        end
    end

    assign done    = done_reg;
    assign pixel_x = pixel_x_reg;
    assign pixel_y = pixel_y_reg;
    assign invalid = invalid_reg;
    assign clipped = clipped_reg;

    // Checks.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(T_S + 2) done)
        else $error("accepted point did not produce a result on time");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && invalid) |-> (pixel_x == 16'sd0 && pixel_y == 16'sd0 && !clipped))
        else $error("invalid result carries a pixel or clip flag");

    a_clip_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && clipped) |-> (pixel_x == 16'sh7fff || pixel_x == 16'sh8000 ||
                               pixel_y == 16'sh7fff || pixel_y == 16'sh8000))
        else $error("clipped result does not sit on a range limit");

endmodule
